// ===== src/sda_pkg.sv =====
// shared types and constants for the scaled decimal accumulator
`timescale 1ns / 1ps
`default_nettype none

package sda_pkg;

    localparam int MAG_W   = 64;
    localparam int HALF_W  = MAG_W / 2;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int EXP_W   = 6;
    localparam int ERR_W   = 2;
    localparam int SCALE_W = EXP_W + 1;

    // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 64-bit x
    localparam logic [MAG_W-1:0] TEN_MAG     = 64'd10;
    localparam logic [MAG_W-1:0] RECIP_TEN   = 64'hCCCC_CCCC_CCCC_CCCD;
    localparam int               RECIP_SHIFT = 67;

    localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NAN  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_INF  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RSVD = 2'd3;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_SUB  = 2'd2,
        ACT_MUL  = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [MAG_W-1:0]   operand_magnitude;
        logic [EXP_W-1:0]   operand_exponent;
        logic               operand_negative;
        logic [ERR_W-1:0]   operand_error;
    } in_item_t;

    typedef struct packed {
        logic [MAG_W-1:0]   result_magnitude;
        logic [EXP_W-1:0]   result_exponent;
        logic               result_negative;
        logic [ERR_W-1:0]   result_error;
    } out_item_t;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic [EXP_W-1:0]   exponent;
        logic               negative;
        logic [ERR_W-1:0]   error;
    } value_t;

endpackage

`default_nettype wire

// ===== src/sda_mul.sv =====
// shared 64x64 multiplier built from four 32x32 partial products
`timescale 1ns / 1ps
`default_nettype none

module sda_mul
    import sda_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [MAG_W-1:0]  a,
    input  wire logic [MAG_W-1:0]  b,
    output logic                   done,
    output logic [PROD_W-1:0]      product
);

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [2:0]         step_reg, step_next;
    logic [MAG_W-1:0]   a_reg, b_reg;
    logic [MAG_W-1:0]   pp_reg, pp_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [HALF_W-1:0]  fa, fb;
    logic [PROD_W-1:0]  addend;

    // pick the halves for this step's partial product
    always_comb begin
        unique case (step_reg)
            3'd0: begin
                fa = a_reg[HALF_W-1:0];
                fb = b_reg[HALF_W-1:0];
            end
            3'd1: begin
                fa = a_reg[HALF_W-1:0];
                fb = b_reg[MAG_W-1:HALF_W];
            end
            3'd2: begin
                fa = a_reg[MAG_W-1:HALF_W];
                fb = b_reg[HALF_W-1:0];
            end
            default: begin
                fa = a_reg[MAG_W-1:HALF_W];
                fb = b_reg[MAG_W-1:HALF_W];
            end
        endcase
    end

    assign pp_next = {{HALF_W{1'b0}}, fa} * {{HALF_W{1'b0}}, fb};

    // weight of the partial product registered in the previous step
    always_comb begin
        unique case (step_reg)
            3'd1:    addend = PROD_W'(pp_reg);
            3'd2,
            3'd3:    addend = PROD_W'(pp_reg) << HALF_W;
            3'd4:    addend = PROD_W'(pp_reg) << MAG_W;
            default: addend = '0;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = busy_reg && (step_reg == LAST_STEP);
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next  = acc_reg + addend;
            step_next = step_reg + 3'd1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end
        if (busy_reg) begin
            pp_reg <= pp_next;
        end
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== src/scaled_decimal_accumulator_core.sv =====
// top level of the scaled decimal accumulator: sequencer, accumulator and result register
`timescale 1ns / 1ps
`default_nettype none

// Keeps one sign-magnitude scaled decimal (magnitude / 10^exponent, with an error
// code) and loads, adds, subtracts or multiplies each input transaction into it,
// returning the accumulator after every step. All scaling and multiplication run
// through one shared 64x64 multiplier, so the cost of an item depends on its data:
// a load or an ignored item never uses it, an add or subtract uses it once per
// decimal digit of the exponent difference being aligned (each digit is one
// multiply by ten), and a multiply uses it once plus twice for each digit
// truncated from the larger-exponent factor (a multiply by the reciprocal of
// ten, then a retry of the product).
// s_ready is high only while the sequencer is idle; the result register lets
// the next transaction enter while the previous result still waits on m_ready.
module scaled_decimal_accumulator_core
    import sda_pkg::*;
#(
    parameter int EXP_LIMIT = 63
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    localparam logic [SCALE_W-1:0] EXP_CAP =
        SCALE_W'((EXP_LIMIT < 63) ? EXP_LIMIT : 63);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_DISPATCH   = 10'b00_0000_0010,
        S_SCALE_GO   = 10'b00_0000_0100,
        S_SCALE_WAIT = 10'b00_0000_1000,
        S_ADD        = 10'b00_0001_0000,
        S_MUL_GO     = 10'b00_0010_0000,
        S_MUL_WAIT   = 10'b00_0100_0000,
        S_DIV_GO     = 10'b00_1000_0000,
        S_DIV_WAIT   = 10'b01_0000_0000,
        S_DONE       = 10'b10_0000_0000
    } state_t;

    function automatic value_t make_invalid(logic [ERR_W-1:0] code);
        value_t v;
        v.magnitude = '0;
        v.exponent  = '0;
        v.negative  = 1'b0;
        v.error     = code;
        return v;
    endfunction

    function automatic value_t make_value(logic [MAG_W-1:0] mag, logic [SCALE_W-1:0] ex,
                                          logic neg);
        value_t v;
        if (ex > EXP_CAP) begin
            v = make_invalid(ERR_INF);
        end else begin
            v.magnitude = mag;
            v.exponent  = ex[EXP_W-1:0];
            v.negative  = neg;
            v.error     = ERR_OK;
        end
        return v;
    endfunction

    state_t             state_reg, state_next;
    value_t             acc_reg, acc_next;
    in_item_t           op_reg, op_next;
    logic [MAG_W-1:0]   x_reg, x_next;
    logic [MAG_W-1:0]   y_reg, y_next;
    logic [EXP_W-1:0]   cnt_reg, cnt_next;
    logic [EXP_W-1:0]   te_reg, te_next;
    logic [EXP_W-1:0]   oe_reg, oe_next;
    logic               scale_acc_reg, scale_acc_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic               mul_start;
    logic [MAG_W-1:0]   mul_b;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_prod;
    logic               prod_ovf;

    logic [ERR_W-1:0]   berr;
    logic               bneg_eff;
    logic [MAG_W-1:0]   am, bm;
    logic [MAG_W:0]     sum;
    logic [MAG_W-1:0]   diff_ab, diff_ba;
    logic               a_gt_b, b_gt_a;
    logic [SCALE_W-1:0] add_ex;
    logic [SCALE_W-1:0] mul_ex;
    logic               out_load;

    sda_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (x_reg),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign mul_start = (state_reg == S_SCALE_GO) || (state_reg == S_MUL_GO)
                       || (state_reg == S_DIV_GO);

    always_comb begin
        priority if (state_reg == S_SCALE_GO) begin
            mul_b = TEN_MAG;
        end else if (state_reg == S_DIV_GO) begin
            mul_b = RECIP_TEN;
        end else begin
            mul_b = y_reg;
        end
    end

    assign prod_ovf = (mul_prod[PROD_W-1:MAG_W] != '0);

    // operand view shared by dispatch and the add step
    assign berr     = (op_reg.operand_error == ERR_RSVD) ? ERR_NAN : op_reg.operand_error;
    assign bneg_eff = (op_reg.action == ACT_SUB) ? ~op_reg.operand_negative
                                                 : op_reg.operand_negative;

    // x holds the aligned value, y the one that kept its exponent
    assign am      = scale_acc_reg ? x_reg : y_reg;
    assign bm      = scale_acc_reg ? y_reg : x_reg;
    assign sum     = {1'b0, am} + {1'b0, bm};
    assign diff_ab = am - bm;
    assign diff_ba = bm - am;
    assign a_gt_b  = am > bm;
    assign b_gt_a  = bm > am;
    assign add_ex  = (acc_reg.exponent > op_reg.operand_exponent)
                     ? {1'b0, acc_reg.exponent} : {1'b0, op_reg.operand_exponent};
    assign mul_ex  = {1'b0, te_reg} + {1'b0, oe_reg};

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        te_next        = te_reg;
        oe_next        = oe_reg;
        scale_acc_next = scale_acc_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                state_next = S_DONE;
                unique case (op_reg.action)
                    ACT_LOAD: begin
                        if (berr != ERR_OK) begin
                            acc_next = make_invalid(berr);
                        end else begin
                            acc_next = make_value(op_reg.operand_magnitude,
                                                  {1'b0, op_reg.operand_exponent},
                                                  op_reg.operand_negative);
                        end
                    end
                    ACT_MUL: begin
                        if (acc_reg.error != ERR_OK) begin
                            state_next = S_DONE;
                        end else if (berr != ERR_OK) begin
                            acc_next = make_invalid(berr);
                        end else begin
                            // truncate the larger-exponent factor, operand on a tie
                            if (acc_reg.exponent > op_reg.operand_exponent) begin
                                x_next  = acc_reg.magnitude;
                                te_next = acc_reg.exponent;
                                y_next  = op_reg.operand_magnitude;
                                oe_next = op_reg.operand_exponent;
                            end else begin
                                x_next  = op_reg.operand_magnitude;
                                te_next = op_reg.operand_exponent;
                                y_next  = acc_reg.magnitude;
                                oe_next = acc_reg.exponent;
                            end
                            state_next = S_MUL_GO;
                        end
                    end
                    default: begin
                        if (acc_reg.error == ERR_OK && berr == ERR_OK) begin
                            if (acc_reg.exponent < op_reg.operand_exponent) begin
                                x_next         = acc_reg.magnitude;
                                y_next         = op_reg.operand_magnitude;
                                scale_acc_next = 1'b1;
                                cnt_next       = op_reg.operand_exponent - acc_reg.exponent;
                                state_next     = S_SCALE_GO;
                            end else begin
                                x_next         = op_reg.operand_magnitude;
                                y_next         = acc_reg.magnitude;
                                scale_acc_next = 1'b0;
                                cnt_next       = acc_reg.exponent - op_reg.operand_exponent;
                                state_next     = (acc_reg.exponent == op_reg.operand_exponent)
                                                 ? S_ADD : S_SCALE_GO;
                            end
                        end
                    end
                endcase
            end

            S_SCALE_GO: begin
                state_next = S_SCALE_WAIT;
            end

            S_SCALE_WAIT: begin
                if (mul_done) begin
                    if (prod_ovf) begin
                        acc_next   = make_invalid(ERR_INF);
                        state_next = S_DONE;
                    end else begin
                        x_next     = mul_prod[MAG_W-1:0];
                        cnt_next   = cnt_reg - EXP_W'(1);
                        state_next = (cnt_reg == EXP_W'(1)) ? S_ADD : S_SCALE_GO;
                    end
                end
            end

            S_ADD: begin
                state_next = S_DONE;
                if (acc_reg.negative == bneg_eff) begin
                    if (sum[MAG_W]) begin
                        acc_next = make_invalid(ERR_INF);
                    end else begin
                        acc_next = make_value(sum[MAG_W-1:0], add_ex, acc_reg.negative);
                    end
                end else if (acc_reg.negative) begin
                    acc_next = a_gt_b ? make_value(diff_ab, add_ex, 1'b1)
                                      : make_value(diff_ba, add_ex, 1'b0);
                end else begin
                    acc_next = b_gt_a ? make_value(diff_ba, add_ex, 1'b1)
                                      : make_value(diff_ab, add_ex, 1'b0);
                end
            end

            S_MUL_GO: begin
                state_next = S_MUL_WAIT;
            end

            S_MUL_WAIT: begin
                if (mul_done) begin
                    if (!prod_ovf) begin
                        acc_next   = make_value(mul_prod[MAG_W-1:0], mul_ex,
                                                acc_reg.negative ^ op_reg.operand_negative);
                        state_next = S_DONE;
                    end else if (te_reg == '0) begin
                        acc_next   = make_invalid(ERR_INF);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_DIV_GO;
                    end
                end
            end

            S_DIV_GO: begin
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT: begin
                if (mul_done) begin
                    x_next     = MAG_W'(mul_prod[PROD_W-1:RECIP_SHIFT]);
                    te_next    = te_reg - EXP_W'(1);
                    state_next = S_MUL_GO;
                end
            end

            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next                 = 1'b1;
            m_data_next.result_magnitude = acc_reg.magnitude;
            m_data_next.result_exponent  = acc_reg.exponent;
            m_data_next.result_negative  = acc_reg.negative;
            m_data_next.result_error     = acc_reg.error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= make_invalid(ERR_OK);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        cnt_reg       <= cnt_next;
        te_reg        <= te_next;
        oe_reg        <= oe_next;
        scale_acc_reg <= scale_acc_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
